/* hdl/imu_angle_frame_parser_defines.svh */
// Assertion macros used by the angle frame parser queue module.
`ifndef IMU_ANGLE_FRAME_PARSER_DEFINES_SVH
`define IMU_ANGLE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled while arst_n is low.
`define IAFP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled while arst_n is low.
`define IAFP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/iafp_pkg.sv */
// Types, constants and the angle scaling function of the angle frame parser.
`default_nettype none
package iafp_pkg;

	localparam int FRAME_LENGTH = 11;
	localparam int CNT_W = 4;
	localparam int ANGLE_W = 24;
	localparam int RAW_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] HEADER_RESET = 8'h55;
	localparam logic [7:0] TYPE_RESET = 8'h53;

	// Register index, taken from paddr[2]
	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_TYPE = 1'b1;

	typedef struct packed {
		logic [RAW_W-1:0] roll_raw;
		logic [RAW_W-1:0] pitch_raw;
		logic [RAW_W-1:0] yaw_raw;
	} raw_frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// raw * 180, exact in units of 1/32768 degree
	function automatic logic signed [ANGLE_W-1:0] scale_angle(input logic signed [RAW_W-1:0] raw);
		logic signed [ANGLE_W:0] prod;
		prod = (ANGLE_W+1)'(raw) * (ANGLE_W+1)'(180);
		return prod[ANGLE_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/iafp_front.sv */
// Front end: byte parser that hunts for header and type and gathers angle bytes.
`default_nettype none
module iafp_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [7:0]          rx_byte,
	input  wire  [7:0]          header_byte,
	input  wire  [7:0]          type_byte,
	input  iafp_pkg::q_status_t q_status,
	output logic                push,
	output iafp_pkg::raw_frame_t push_frame
);
	import iafp_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_TYPE = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	phase_t           phase_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       angle_q [6];
	logic [7:0]       angle_next [6];
	logic             accept;
	logic [CNT_W:0]   cnt_next;
	logic [2:0]       store_idx;
	logic             store_en;
	logic             frame_done;

	assign in_stall = q_status.full;
	assign accept = in_valid && !in_stall;
	assign cnt_next = {1'b0, count_q} + (CNT_W+1)'(1);
	assign store_idx = 3'(count_q - CNT_W'(2));
	assign store_en = accept && (phase_q == PH_DATA)
		&& (count_q >= CNT_W'(2)) && (count_q <= CNT_W'(7));
	assign frame_done = accept && (phase_q == PH_DATA)
		&& (cnt_next >= (CNT_W+1)'(FRAME_LENGTH));

	always_comb begin
		angle_next = angle_q;
		if (store_en) begin
			angle_next[store_idx] = rx_byte;
		end
	end

	assign push = frame_done;
	assign push_frame.roll_raw = {angle_next[1], angle_next[0]};
	assign push_frame.pitch_raw = {angle_next[3], angle_next[2]};
	assign push_frame.yaw_raw = {angle_next[5], angle_next[4]};

	always_ff @(posedge clk) begin
		angle_q <= angle_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == header_byte) begin
						phase_q <= PH_TYPE;
						count_q <= CNT_W'(1);
					end
				end
				PH_TYPE: begin
					if (rx_byte == type_byte) begin
						phase_q <= PH_DATA;
						count_q <= CNT_W'(2);
					end else begin
						phase_q <= PH_HUNT;
						count_q <= '0;
					end
				end
				PH_DATA: begin
					if (frame_done) begin
						phase_q <= PH_HUNT;
						count_q <= '0;
					end else begin
						count_q <= cnt_next[CNT_W-1:0];
					end
				end
				default: begin
					phase_q <= PH_HUNT;
					count_q <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/iafp_queue.sv */
// Short frame queue between the parser and the scaling stage.
`default_nettype none
`include "imu_angle_frame_parser_defines.svh"
module iafp_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  iafp_pkg::raw_frame_t push_frame,
	input  wire                  pop,
	output iafp_pkg::raw_frame_t pop_frame,
	output iafp_pkg::q_status_t  q_status
);
	import iafp_pkg::*;

	raw_frame_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`IAFP_ASSERT_IMP(a_no_push_full, push, !q_status.full, "frame pushed into full queue")
	`IAFP_ASSERT_IMP(a_no_pop_empty, pop, !q_status.empty, "frame popped from empty queue")
	`IAFP_ASSERT_NXT(a_push_not_empty, push, !q_status.empty, "queue empty after push")

endmodule
`default_nettype wire

/* hdl/iafp_scale.sv */
// Back end: scales the raw angles by 180 into the output register.
`default_nettype none
module iafp_scale (
	input  wire                        clk,
	input  wire                        arst_n,
	input  iafp_pkg::q_status_t        q_status,
	input  iafp_pkg::raw_frame_t       pop_frame,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [iafp_pkg::ANGLE_W-1:0] roll_angle,
	output logic signed [iafp_pkg::ANGLE_W-1:0] pitch_angle,
	output logic signed [iafp_pkg::ANGLE_W-1:0] yaw_angle
);
	import iafp_pkg::*;

	logic                      valid_q;
	logic signed [ANGLE_W-1:0] roll_q;
	logic signed [ANGLE_W-1:0] pitch_q;
	logic signed [ANGLE_W-1:0] yaw_q;

	assign pop = !q_status.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign roll_angle = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			roll_q <= scale_angle(pop_frame.roll_raw);
			pitch_q <= scale_angle(pop_frame.pitch_raw);
			yaw_q <= scale_angle(pop_frame.yaw_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* hdl/imu_angle_frame_parser.sv */
// Top level of the inertial sensor angle frame parser.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid / in_stall     | rx_byte
//   out     | output    | out_valid / out_stall   | roll_angle, pitch_angle, yaw_angle
//   cfg     | input     | psel/penable/pwrite     | paddr, pwdata (read via prdata)
//
// One byte transfer per cycle while in_stall is low; the parser state updates in the same cycle.
// A frame result is written into a two-entry frame queue with its last byte, then into the output
// register, once that is free, through one 16x9 multiply per angle.
// in_stall rises only while the frame queue is full (output held by out_stall).
// arst_n clears parse phase, byte count, queue pointers and output valid;
// header and type registers return to 0x55 and 0x53.
`default_nettype none
module imu_angle_frame_parser (
	input  wire         clk,
	input  wire         arst_n,
	// byte input
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  rx_byte,
	// angle output
	output logic        out_valid,
	input  wire         out_stall,
	output logic signed [iafp_pkg::ANGLE_W-1:0] roll_angle,
	output logic signed [iafp_pkg::ANGLE_W-1:0] pitch_angle,
	output logic signed [iafp_pkg::ANGLE_W-1:0] yaw_angle,
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import iafp_pkg::*;

	logic [7:0] header_q;
	logic [7:0] type_q;
	logic       cfg_write;
	logic       reg_sel;

	q_status_t  q_status;
	logic       push;
	raw_frame_t push_frame;
	logic       pop;
	raw_frame_t pop_frame;

	// Register file: zero wait states, index decoded from paddr[2]
	assign pready = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			type_q <= TYPE_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_HEADER: header_q <= pwdata[7:0];
				REG_TYPE: type_q <= pwdata[7:0];
				default: header_q <= header_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HEADER: prdata = {24'd0, header_q};
			REG_TYPE: prdata = {24'd0, type_q};
			default: prdata = '0;
		endcase
	end

	// Front: parse bytes, push completed frames
	iafp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.header_byte(header_q),
		.type_byte  (type_q),
		.q_status   (q_status),
		.push       (push),
		.push_frame (push_frame)
	);

	// Decouple parser from output backpressure
	iafp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.pop       (pop),
		.pop_frame (pop_frame),
		.q_status  (q_status)
	);

	// Back: scale and hold the result until the transfer completes
	iafp_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.pop_frame  (pop_frame),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.roll_angle (roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle  (yaw_angle)
	);

endmodule
`default_nettype wire
